FILE: hw/rtl/vrst_pkg.sv
// Shared types, constants and the saturation helper for the vertex transform.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package vrst_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [65:0] t_wide;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;
    localparam int NUM_AXES  = 3;
    localparam int NUM_STG   = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_X = 3'd0,
        REG_ROT_Y = 3'd1,
        REG_ROT_Z = 3'd2,
        REG_X_SCL = 3'd3,
        REG_Y_SCL = 3'd4,
        REG_Z_SCL = 3'd5
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_ROT = 64'h4000_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_SCL = 64'h0001_0000_0000_0000;

    localparam t_wide Q_MAX = 66'sd2147483647;
    localparam t_wide Q_MIN = -66'sd2147483648;

    typedef struct packed {
        logic ld_mul;
        logic ld_sum;
    } t_rot_en;

    typedef struct packed {
        logic ld_mul;
        logic ld_rnd;
        logic ld_off;
    } t_scl_en;

    typedef struct packed {
        t_q16 val;
        logic clip;
    } t_sat;

    function automatic t_sat sat32(input t_wide v);
        t_sat r;
        r.val  = t_q16'(v[31:0]);
        r.clip = 1'b0;
        if (v > Q_MAX) begin
            r.val  = t_q16'(Q_MAX[31:0]);
            r.clip = 1'b1;
        end else if (v < Q_MIN) begin
            r.val  = t_q16'(Q_MIN[31:0]);
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/vrst_in_if.sv
// Input channel of the vertex transform: one vertex per word.
// Depends on vrst_pkg for the coordinate type.
`timescale 1ns / 1ps
interface vrst_in_if
    import vrst_pkg::*;
();
    logic valid;
    logic ready;
    t_q16 in_x;
    t_q16 in_y;
    t_q16 in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

FILE: hw/rtl/vrst_out_if.sv
// Output channel of the vertex transform: one transformed vertex per word.
// Depends on vrst_pkg for the coordinate type.
`timescale 1ns / 1ps
interface vrst_out_if
    import vrst_pkg::*;
();
    logic valid;
    logic ready;
    t_q16 out_x;
    t_q16 out_y;
    t_q16 out_z;
    logic clipped;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input clipped, output ready);
endinterface

FILE: hw/rtl/vrst_rot.sv
// Two-stage plane rotation: products in the first stage, rounded and
// saturated sums in the second. Depends on vrst_pkg.
`timescale 1ns / 1ps
module vrst_rot
    import vrst_pkg::*;
(
    input  logic    i_clk,
    input  t_rot_en i_ctl,
    input  t_q16    i_c,
    input  t_q16    i_s,
    input  t_q16    i_a,
    input  t_q16    i_b,
    input  t_q16    i_p,
    input  logic    i_clip,
    output t_q16    o_a,
    output t_q16    o_b,
    output t_q16    o_p,
    output logic    o_clip
);
    localparam t_wide RND30 = t_wide'(66'sd1 <<< 29);

    t_prod r_ac, r_bs, r_as, r_bc;
    t_q16  r_p0, r_a1, r_b1, r_p1;
    logic  r_clip0, r_clip1;

    t_wide w_sa, w_sb;
    t_sat  w_ra, w_rb;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            r_ac    <= i_a * i_c;
            r_bs    <= i_b * i_s;
            r_as    <= i_a * i_s;
            r_bc    <= i_b * i_c;
            r_p0    <= i_p;
            r_clip0 <= i_clip;
        end
    end

    always_comb begin
        w_sa = (t_wide'(r_ac) - t_wide'(r_bs) + RND30) >>> 30;
        w_sb = (t_wide'(r_as) + t_wide'(r_bc) + RND30) >>> 30;
        w_ra = sat32(w_sa);
        w_rb = sat32(w_sb);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_a1    <= w_ra.val;
            r_b1    <= w_rb.val;
            r_p1    <= r_p0;
            r_clip1 <= r_clip0 | w_ra.clip | w_rb.clip;
        end
    end

    assign o_a    = r_a1;
    assign o_b    = r_b1;
    assign o_p    = r_p1;
    assign o_clip = r_clip1;
endmodule

FILE: hw/rtl/vrst_scale.sv
// Three-stage scale and translate for all three axes: product, rounding
// with saturation, then offset with saturation. Depends on vrst_pkg.
`timescale 1ns / 1ps
module vrst_scale
    import vrst_pkg::*;
(
    input  logic    i_clk,
    input  t_scl_en i_ctl,
    input  t_q16    i_v   [NUM_AXES],
    input  t_q16    i_sc  [NUM_AXES],
    input  t_q16    i_off [NUM_AXES],
    input  logic    i_clip,
    output t_q16    o_v   [NUM_AXES],
    output logic    o_clip
);
    localparam t_wide RND16 = t_wide'(66'sd1 <<< 15);

    t_prod r_prod [NUM_AXES];
    t_q16  r_rnd  [NUM_AXES];
    t_q16  r_out  [NUM_AXES];
    logic  r_clip0, r_clip1, r_clip2;

    t_sat  w_rnd  [NUM_AXES];
    t_sat  w_out  [NUM_AXES];
    logic  w_clip_rnd, w_clip_out;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_prod[k] <= i_v[k] * i_sc[k];
            end
            r_clip0 <= i_clip;
        end
    end

    always_comb begin
        w_clip_rnd = 1'b0;
        w_clip_out = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            w_rnd[k]   = sat32((t_wide'(r_prod[k]) + RND16) >>> 16);
            w_out[k]   = sat32(t_wide'(r_rnd[k]) + t_wide'(i_off[k]));
            w_clip_rnd = w_clip_rnd | w_rnd[k].clip;
            w_clip_out = w_clip_out | w_out[k].clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_rnd) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_rnd[k] <= w_rnd[k].val;
            end
            r_clip1 <= r_clip0 | w_clip_rnd;
        end
        if (i_ctl.ld_off) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_out[k] <= w_out[k].val;
            end
            r_clip2 <= r_clip1 | w_clip_out;
        end
    end

    assign o_v    = r_out;
    assign o_clip = r_clip2;
endmodule

FILE: hw/rtl/vertex_rotate_scale_translate.sv
// Top level of the vertex transform: configuration registers, pipeline
// control, three rotation units and the scale stage. Depends on vrst_pkg,
// vrst_in_if, vrst_out_if, vrst_rot and vrst_scale.
//
// The block rotates each Q16.16 vertex about X, then Y, then Z with the
// loaded Q2.30 cosine and sine pairs, then scales and translates each axis,
// saturating every step and flagging any saturation in clipped. It takes
// one vertex per cycle unless a stalled output has filled every stage.
// Each rotation unit is a multiply stage and a rounding sum stage, and the
// scale path is a multiply, a rounding and an offset stage. The last stage
// is the output register, and a stalled output holds only the stages that
// are occupied, so empty stages keep accepting words. Write registers only
// while no vertex is in flight.
`timescale 1ns / 1ps
module vertex_rotate_scale_translate
    import vrst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    vrst_in_if.sink              i_vtx,
    vrst_out_if.source           o_vtx
);
    logic [CFG_W-1:0]   r_cfg [NUM_REGS];
    logic [NUM_STG-1:0] r_vld, n_vld, w_en;

    t_q16 w_x1, w_y1, w_z1, w_x2, w_y2, w_z2, w_x3, w_y3, w_z3;
    logic w_clip1, w_clip2, w_clip3, w_clip_out;
    t_q16 w_sv [NUM_AXES];
    t_q16 w_sc [NUM_AXES];
    t_q16 w_off [NUM_AXES];
    t_q16 w_ov [NUM_AXES];

    t_rot_en w_ctl_x, w_ctl_y, w_ctl_z;
    t_scl_en w_ctl_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ROT_X] <= RST_ROT;
            r_cfg[REG_ROT_Y] <= RST_ROT;
            r_cfg[REG_ROT_Z] <= RST_ROT;
            r_cfg[REG_X_SCL] <= RST_SCL;
            r_cfg[REG_Y_SCL] <= RST_SCL;
            r_cfg[REG_Z_SCL] <= RST_SCL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROT_X: r_cfg[REG_ROT_X] <= i_cfg_data;
                REG_ROT_Y: r_cfg[REG_ROT_Y] <= i_cfg_data;
                REG_ROT_Z: r_cfg[REG_ROT_Z] <= i_cfg_data;
                REG_X_SCL: r_cfg[REG_X_SCL] <= i_cfg_data;
                REG_Y_SCL: r_cfg[REG_Y_SCL] <= i_cfg_data;
                REG_Z_SCL: r_cfg[REG_Z_SCL] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_en[NUM_STG-1] = ~r_vld[NUM_STG-1] | o_vtx.ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_vtx.valid;
        end
        for (int k = 1; k < NUM_STG; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_ctl_x = '{ld_mul: w_en[0], ld_sum: w_en[1]};
    assign w_ctl_y = '{ld_mul: w_en[2], ld_sum: w_en[3]};
    assign w_ctl_z = '{ld_mul: w_en[4], ld_sum: w_en[5]};
    assign w_ctl_s = '{ld_mul: w_en[6], ld_rnd: w_en[7], ld_off: w_en[8]};

    vrst_rot u_rot_x (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl_x),
        .i_c    (t_q16'(r_cfg[REG_ROT_X][63:32])),
        .i_s    (t_q16'(r_cfg[REG_ROT_X][31:0])),
        .i_a    (i_vtx.in_y),
        .i_b    (i_vtx.in_z),
        .i_p    (i_vtx.in_x),
        .i_clip (1'b0),
        .o_a    (w_y1),
        .o_b    (w_z1),
        .o_p    (w_x1),
        .o_clip (w_clip1)
    );

    vrst_rot u_rot_y (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl_y),
        .i_c    (t_q16'(r_cfg[REG_ROT_Y][63:32])),
        .i_s    (t_q16'(r_cfg[REG_ROT_Y][31:0])),
        .i_a    (w_z1),
        .i_b    (w_x1),
        .i_p    (w_y1),
        .i_clip (w_clip1),
        .o_a    (w_z2),
        .o_b    (w_x2),
        .o_p    (w_y2),
        .o_clip (w_clip2)
    );

    vrst_rot u_rot_z (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl_z),
        .i_c    (t_q16'(r_cfg[REG_ROT_Z][63:32])),
        .i_s    (t_q16'(r_cfg[REG_ROT_Z][31:0])),
        .i_a    (w_x2),
        .i_b    (w_y2),
        .i_p    (w_z2),
        .i_clip (w_clip2),
        .o_a    (w_x3),
        .o_b    (w_y3),
        .o_p    (w_z3),
        .o_clip (w_clip3)
    );

    always_comb begin
        w_sv[0]  = w_x3;
        w_sv[1]  = w_y3;
        w_sv[2]  = w_z3;
        w_sc[0]  = t_q16'(r_cfg[REG_X_SCL][63:32]);
        w_sc[1]  = t_q16'(r_cfg[REG_Y_SCL][63:32]);
        w_sc[2]  = t_q16'(r_cfg[REG_Z_SCL][63:32]);
        w_off[0] = t_q16'(r_cfg[REG_X_SCL][31:0]);
        w_off[1] = t_q16'(r_cfg[REG_Y_SCL][31:0]);
        w_off[2] = t_q16'(r_cfg[REG_Z_SCL][31:0]);
    end

    vrst_scale u_scale (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl_s),
        .i_v    (w_sv),
        .i_sc   (w_sc),
        .i_off  (w_off),
        .i_clip (w_clip3),
        .o_v    (w_ov),
        .o_clip (w_clip_out)
    );

    assign i_vtx.ready   = w_en[0];
    assign o_vtx.valid   = r_vld[NUM_STG-1];
    assign o_vtx.out_x   = w_ov[0];
    assign o_vtx.out_y   = w_ov[1];
    assign o_vtx.out_z   = w_ov[2];
    assign o_vtx.clipped = w_clip_out;

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !w_en[4]) |=> r_vld[4])
        else $error("occupied pipeline stage dropped its word while stalled");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en[0] |-> ((&r_vld) && !o_vtx.ready))
        else $error("input blocked while the pipeline has a free stage");

    a_cfg_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cfg[REG_ROT_X] == RST_ROT && r_cfg[REG_Z_SCL] == RST_SCL))
        else $error("configuration registers not at their reset values");
endmodule

FILE: bench/vertex_rotate_scale_translate_tb.sv
// Self-checking testbench for vertex_rotate_scale_translate: streams vertices
// under changing register settings, checks words against a predictor or fixed values.
// Depends on vrst_pkg, vrst_in_if, vrst_out_if and the block itself.
`timescale 1ns / 1ps
module vertex_rotate_scale_translate_tb
    import vrst_pkg::*;
();

    localparam int LATENCY     = 9;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int BLOCKS      = 9;
    localparam int BLOCK_LEN   = 50;
    localparam int PRINT_CAP   = 30;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam t_q16 Q_MAX  = 32'sh7FFF_FFFF;
    localparam t_q16 Q_MIN  = 32'sh8000_0000;
    localparam t_q16 Q_ONE  = 32'sh0001_0000;
    localparam t_q16 Q_TWO  = 32'sh0002_0000;
    localparam t_q16 Q_HALF = 32'sh0000_8000;
    localparam t_q16 Q_LSB  = 32'sh0000_0001;
    localparam t_q16 TRIG_ONE  = 32'sh4000_0000;
    localparam t_q16 TRIG_HALF = 32'sh2000_0000;

    typedef logic signed [79:0] t_acc;
    localparam t_acc ACC_MAX = 80'sd2147483647;
    localparam t_acc ACC_MIN = -80'sd2147483648;

    typedef struct packed {
        t_q16 x;
        t_q16 y;
        t_q16 z;
        logic clipped;
    } t_vtx_word;

    typedef struct {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_q16                 x;
        t_q16                 y;
        t_q16                 z;
        logic                 known;
        t_vtx_word            want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    vrst_in_if  vin();
    vrst_out_if vout();

    vertex_rotate_scale_translate DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (vin),
        .o_vtx      (vout)
    );

    logic [CFG_W-1:0] reg_shadow [NUM_REGS];
    t_vtx_word        pending_vtx [$];
    t_stim_row        stim_rows [$];

    int src_idle_pct;
    int snk_idle_pct;
    int mismatch_count;
    int words_checked;
    int clipped_seen;
    int vertices_sent;
    int writes_done;
    int cycle_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] word %0d %s: got %h, expected %h",
                     $realtime, words_checked, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_acc hi_word(input logic [CFG_W-1:0] r);
        return t_acc'($signed(r[63:32]));
    endfunction

    function automatic t_acc lo_word(input logic [CFG_W-1:0] r);
        return t_acc'($signed(r[31:0]));
    endfunction

    function automatic t_sat clamp_q16(input t_acc v);
        t_sat r;
        r.clip = 1'b1;
        if (v > ACC_MAX) begin
            r.val = Q_MAX;
        end else if (v < ACC_MIN) begin
            r.val = Q_MIN;
        end else begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // Round half up: add half an output step, then shift toward minus infinity.
    function automatic t_acc round_down(input t_acc v, input int k);
        return (v + (t_acc'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic t_sat rotate_term(input t_q16 a, input t_acc ca,
                                         input t_q16 b, input t_acc cb);
        t_acc pa;
        t_acc pb;
        pa = t_acc'(a) * ca;
        pb = t_acc'(b) * cb;
        return clamp_q16(round_down(pa + pb, 30));
    endfunction

    function automatic t_sat scale_axis(input t_q16 v, input logic [CFG_W-1:0] r);
        t_sat p;
        t_sat q;
        p = clamp_q16(round_down(t_acc'(v) * hi_word(r), 16));
        q = clamp_q16(t_acc'(p.val) + lo_word(r));
        q.clip = q.clip | p.clip;
        return q;
    endfunction

    function automatic t_vtx_word transform_vertex(input t_q16 x, input t_q16 y,
                                                   input t_q16 z);
        t_vtx_word res;
        t_sat r0;
        t_sat r1;
        t_acc c;
        t_acc s;
        logic clip;
        clip = 1'b0;

        c  = hi_word(reg_shadow[REG_ROT_X]);
        s  = lo_word(reg_shadow[REG_ROT_X]);
        r0 = rotate_term(y, c, z, -s);
        r1 = rotate_term(y, s, z, c);
        y  = r0.val;
        z  = r1.val;
        clip |= r0.clip | r1.clip;

        c  = hi_word(reg_shadow[REG_ROT_Y]);
        s  = lo_word(reg_shadow[REG_ROT_Y]);
        r0 = rotate_term(x, c, z, s);
        r1 = rotate_term(x, -s, z, c);
        x  = r0.val;
        z  = r1.val;
        clip |= r0.clip | r1.clip;

        c  = hi_word(reg_shadow[REG_ROT_Z]);
        s  = lo_word(reg_shadow[REG_ROT_Z]);
        r0 = rotate_term(x, c, y, -s);
        r1 = rotate_term(x, s, y, c);
        x  = r0.val;
        y  = r1.val;
        clip |= r0.clip | r1.clip;

        r0 = scale_axis(x, reg_shadow[REG_X_SCL]);
        res.x = r0.val;
        clip |= r0.clip;
        r0 = scale_axis(y, reg_shadow[REG_Y_SCL]);
        res.y = r0.val;
        clip |= r0.clip;
        r0 = scale_axis(z, reg_shadow[REG_Z_SCL]);
        res.z = r0.val;
        clip |= r0.clip;
        res.clipped = clip;
        return res;
    endfunction

    function automatic t_q16 rand_span(input int unsigned half);
        return t_q16'($urandom_range(0, 2 * half)) - t_q16'(half);
    endfunction

    function automatic t_q16 rand_coord();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3, 4, 5: return rand_span(32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_trig();
        case ($urandom_range(0, 5))
            0: return RST_ROT;
            1: return {Q_MAX, Q_MAX};
            2: return {Q_MIN, Q_MIN};
            3: return {$urandom, $urandom};
            default: return {rand_span(32'h4000_0000), rand_span(32'h4000_0000)};
        endcase
    endfunction

    function automatic t_q16 rand_scale();
        case ($urandom_range(0, 5))
            0: return Q_ONE;
            1: return Q_MAX;
            2: return Q_MIN;
            3: return $urandom;
            default: return rand_span(32'h0004_0000);
        endcase
    endfunction

    function automatic t_q16 rand_offset();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return Q_MAX;
            2: return Q_MIN;
            3: return $urandom;
            default: return rand_span(32'h0040_0000);
        endcase
    endfunction

    function automatic void put_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        t_stim_row row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.data     = data;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void put_vertex(input t_q16 x, input t_q16 y, input t_q16 z);
        t_stim_row row;
        row = '{default: '0};
        row.x = x;
        row.y = y;
        row.z = z;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void put_known(input t_q16 x, input t_q16 y, input t_q16 z,
                                      input t_q16 ex, input t_q16 ey, input t_q16 ez,
                                      input logic clip);
        t_stim_row row;
        row = '{default: '0};
        row.x     = x;
        row.y     = y;
        row.z     = z;
        row.known = 1'b1;
        row.want  = '{x: ex, y: ey, z: ez, clipped: clip};
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // The first rows run with the reset settings, where the transform is identity.
    function automatic void build_directed();
        put_known('0, '0, '0, '0, '0, '0, 1'b0);
        put_known(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        put_known(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        put_known(32'sh5555_5555, 32'shAAAA_AAAA, Q_ONE,
                  32'sh5555_5555, 32'shAAAA_AAAA, Q_ONE, 1'b0);

        put_write(REG_X_SCL, {Q_TWO, 32'h0});
        put_known(Q_MAX, Q_ONE, '0, Q_MAX, Q_ONE, '0, 1'b1);
        put_known(Q_MIN, '0, '0, Q_MIN, '0, '0, 1'b1);

        put_write(REG_X_SCL, {Q_ONE, Q_MAX});
        put_known(Q_LSB, '0, '0, Q_MAX, '0, '0, 1'b1);
        put_known(Q_MIN, '0, '0, -32'sd1, '0, '0, 1'b0);

        put_write(REG_X_SCL, {Q_MIN, Q_MIN});
        put_write(REG_Y_SCL, {Q_HALF, 32'h0});
        put_write(REG_Z_SCL, {32'h0, Q_MAX});
        put_vertex(Q_MIN, Q_LSB, -32'sd1);
        put_vertex(-32'sd1, -32'sd1, Q_LSB);

        put_write(REG_X_SCL, RST_SCL);
        put_write(REG_Y_SCL, RST_SCL);
        put_write(REG_Z_SCL, RST_SCL);
        put_write(REG_ROT_X, {Q_MIN, Q_MIN});
        put_vertex('0, Q_MIN, Q_MIN);
        put_vertex(Q_ONE, Q_MAX, Q_LSB);

        put_write(REG_ROT_X, RST_ROT);
        put_write(REG_ROT_Y, {Q_MAX, Q_MAX});
        put_write(REG_ROT_Z, {32'h0, TRIG_ONE});
        put_vertex(Q_ONE, '0, '0);
        put_vertex(Q_MAX, Q_MIN, Q_MAX);
        put_vertex(32'sh0003_8000, 32'shFFFE_4000, Q_LSB);

        put_write(REG_ROT_Y, RST_ROT);
        put_write(REG_ROT_Z, {TRIG_HALF, 32'h0});
        put_vertex(Q_LSB, -32'sd1, 32'sd3);
        put_vertex(-32'sd3, 32'sd3, '0);

        put_write(REG_UNMAPPED_LO, {$urandom, $urandom});
        put_write(REG_UNMAPPED_HI, {$urandom, $urandom});
        put_write(REG_ROT_Z, RST_ROT);
        put_known(32'sh1234_5678, Q_MIN, Q_MAX, 32'sh1234_5678, Q_MIN, Q_MAX, 1'b0);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < NUM_REGS)
            reg_shadow[idx] = data;
        writes_done++;
    endtask

    task automatic drain_pipeline();
        vin.valid <= 1'b0;
        while (pending_vtx.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_vertex(input t_q16 x, input t_q16 y, input t_q16 z,
                               input logic known, input t_vtx_word want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            vin.valid <= 1'b0;
            @(posedge i_clk);
        end
        vin.valid <= 1'b1;
        vin.in_x  <= x;
        vin.in_y  <= y;
        vin.in_z  <= z;
        do
            @(posedge i_clk);
        while (vin.ready !== 1'b1);
        pending_vtx.insert(pending_vtx.size(), known ? want : transform_vertex(x, y, z));
        vertices_sent++;
    endtask

    task automatic randomize_settings();
        int forced;
        int idx;
        forced = $urandom_range(0, NUM_REGS - 1);
        for (idx = 0; idx < NUM_REGS; idx++) begin
            if (idx == forced || $urandom_range(0, 9) < 7) begin
                if (idx <= REG_ROT_Z)
                    write_reg(CFG_IDX_W'(idx), rand_trig());
                else
                    write_reg(CFG_IDX_W'(idx), {rand_scale(), rand_offset()});
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin : out_check
        t_vtx_word head;
        if (i_rst_n && vout.valid === 1'b1 && vout.ready === 1'b1) begin
            if (pending_vtx.size() == 0) begin
                report_mismatch("arrived with nothing pending", vout.out_x, '0);
            end else begin
                head = pending_vtx.pop_front();
                if (vout.out_x !== head.x)
                    report_mismatch("out_x", vout.out_x, head.x);
                if (vout.out_y !== head.y)
                    report_mismatch("out_y", vout.out_y, head.y);
                if (vout.out_z !== head.z)
                    report_mismatch("out_z", vout.out_z, head.z);
                if (vout.clipped !== head.clipped)
                    report_mismatch("clipped", 32'(vout.clipped), 32'(head.clipped));
                if (head.clipped)
                    clipped_seen++;
            end
            words_checked++;
        end
        vout.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words pending.",
                     cycle_count, pending_vtx.size());
            $display("vertex_rotate_scale_translate_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int b;
        int n;
        int r;
        logic cfg_active;
        int src_mix [3];
        int snk_mix [3];
        src_mix = '{19, 86, 0};
        snk_mix = '{86, 19, 0};

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        vin.valid  <= 1'b0;
        vin.in_x   <= '0;
        vin.in_y   <= '0;
        vin.in_z   <= '0;
        vertices_sent  = 0;
        writes_done    = 0;
        src_idle_pct   = src_mix[0];
        snk_idle_pct   = snk_mix[0];
        for (r = 0; r < NUM_REGS; r++)
            reg_shadow[r] = (r <= REG_ROT_Z) ? RST_ROT : RST_SCL;
        build_directed();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_active = 1'b0;
        foreach (stim_rows[k]) begin
            if (stim_rows[k].is_write) begin
                if (!cfg_active)
                    drain_pipeline();
                write_reg(stim_rows[k].idx, stim_rows[k].data);
                cfg_active = 1'b1;
            end else begin
                if (cfg_active) begin
                    i_cfg_we <= 1'b0;
                    cfg_active = 1'b0;
                end
                send_vertex(stim_rows[k].x, stim_rows[k].y, stim_rows[k].z,
                            stim_rows[k].known, stim_rows[k].want);
            end
        end
        n = vertices_sent;

        for (b = 0; b < BLOCKS; b++) begin
            drain_pipeline();
            src_idle_pct = src_mix[b / 3];
            snk_idle_pct = snk_mix[b / 3];
            randomize_settings();
            for (r = 0; r < BLOCK_LEN; r++)
                send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
        end

        drain_pipeline();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (pending_vtx.size() != 0)
            report_mismatch("words never returned", pending_vtx.size(), '0);

        $display("Checked %0d words from %0d vertices (%0d directed), %0d saturated.",
                 words_checked, vertices_sent, n, clipped_seen);
        $display("Used %0d register writes, three idle mixes, a full drain before each.",
                 writes_done);
        if (mismatch_count == 0) begin
            $display("vertex_rotate_scale_translate_tb: PASS");
        end else begin
            $display("vertex_rotate_scale_translate_tb: FAIL");
        end
        $finish;
    end

endmodule
